/* rtl/xmodem_crc_block_sender_defines.svh */
// Assertion macros for the top block, which checks itself.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef XMODEM_CRC_BLOCK_SENDER_DEFINES_SVH
`define XMODEM_CRC_BLOCK_SENDER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCBS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCBS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xcbs_pkg.sv */
package xcbs_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int BUF_AW      = $clog2(BLOCK_BYTES);
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int OPCODE_W    = 3;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 4;
  localparam int COUNT_W     = 16;

  localparam logic [7:0]  CH_SOH   = 8'h01;
  localparam logic [7:0]  CH_EOT   = 8'h04;
  localparam logic [7:0]  CH_ACK   = 8'h06;
  localparam logic [7:0]  CH_C     = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Header bytes ahead of the data, the position of the CRC high byte, and the load count of the last data byte.
  localparam logic [7:0] HDR_BYTES = 8'd3;
  localparam logic [7:0] POS_CRC_HI = HDR_BYTES + 8'(BLOCK_BYTES);
  localparam logic [7:0] POS_LAST_DATA_LOAD = 8'(BLOCK_BYTES - 1);

  localparam logic [15:0] RST_START_WAIT = 16'd5000;
  localparam logic [15:0] RST_ACK_WAIT   = 16'd100;
  localparam logic [15:0] RST_RETRY      = 16'd3000;
  localparam logic [15:0] RST_FINAL_WAIT = 16'd1000;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_PAYLOAD = 3'd1,
    OP_RX      = 3'd2,
    OP_TICK    = 3'd3,
    OP_TXSLOT  = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_WAITC     = 4'd1,
    PH_LOAD      = 4'd2,
    PH_SEND      = 4'd3,
    PH_WAITACK   = 4'd4,
    PH_EOT       = 4'd5,
    PH_FINAL     = 4'd6,
    PH_DONE      = 4'd7,
    PH_TMO_START = 4'd8,
    PH_TMO_BLOCK = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    REG_TOTAL_BLOCKS = 3'd0,
    REG_START_WAIT   = 3'd1,
    REG_ACK_WAIT     = 3'd2,
    REG_BLOCK_RETRY  = 3'd3,
    REG_FINAL_WAIT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] total_blocks;
    logic [15:0] start_wait_ticks;
    logic [15:0] ack_wait_ticks;
    logic [15:0] block_retry_ticks;
    logic [15:0] final_wait_ticks;
  } cfg_t;

  // Buffer access requests from the sequencer to the block buffer.
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } buf_req_t;

  // One processed request on its way to the result channel.
  typedef struct packed {
    logic        tx_valid;
    logic        use_buf;
    logic [7:0]  tx_byte;
    phase_t      status;
    logic [15:0] current_block;
  } step_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/xcbs_event_if.sv */
interface xcbs_event_if;
  logic                          valid;
  logic                          ready;
  logic [xcbs_pkg::OPCODE_W-1:0] opcode;
  logic [xcbs_pkg::BYTE_W-1:0]   value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

/* rtl/xcbs_result_if.sv */
interface xcbs_result_if;
  logic                          valid;
  logic                          ready;
  logic                          tx_valid;
  logic [xcbs_pkg::BYTE_W-1:0]   tx_byte;
  logic [xcbs_pkg::STATUS_W-1:0] status;
  logic [xcbs_pkg::COUNT_W-1:0]  current_block;

  modport source (output valid, tx_valid, tx_byte, status, current_block, input ready);
  modport sink   (input valid, tx_valid, tx_byte, status, current_block, output ready);
endinterface

/* rtl/xcbs_ram.sv */
module xcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/xcbs_regs.sv */
module xcbs_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xcbs_pkg::PADDR_W-1:0] paddr,
  input  logic [xcbs_pkg::PDATA_W-1:0] pwdata,
  output logic [xcbs_pkg::PDATA_W-1:0] prdata,
  output xcbs_pkg::cfg_t               cfg
);
  import xcbs_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_blocks      <= '0;
      cfg.start_wait_ticks  <= RST_START_WAIT;
      cfg.ack_wait_ticks    <= RST_ACK_WAIT;
      cfg.block_retry_ticks <= RST_RETRY;
      cfg.final_wait_ticks  <= RST_FINAL_WAIT;
    end else if (wr) begin
      case (idx)
        REG_TOTAL_BLOCKS: cfg.total_blocks      <= pwdata[15:0];
        REG_START_WAIT:   cfg.start_wait_ticks  <= pwdata[15:0];
        REG_ACK_WAIT:     cfg.ack_wait_ticks    <= pwdata[15:0];
        REG_BLOCK_RETRY:  cfg.block_retry_ticks <= pwdata[15:0];
        REG_FINAL_WAIT:   cfg.final_wait_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TOTAL_BLOCKS: prdata = {16'h0000, cfg.total_blocks};
      REG_START_WAIT:   prdata = {16'h0000, cfg.start_wait_ticks};
      REG_ACK_WAIT:     prdata = {16'h0000, cfg.ack_wait_ticks};
      REG_BLOCK_RETRY:  prdata = {16'h0000, cfg.block_retry_ticks};
      REG_FINAL_WAIT:   prdata = {16'h0000, cfg.final_wait_ticks};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/xcbs_ctrl.sv */
module xcbs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [xcbs_pkg::OPCODE_W-1:0] opcode,
  input  logic [xcbs_pkg::BYTE_W-1:0]   value,
  input  xcbs_pkg::cfg_t                cfg,
  output xcbs_pkg::buf_req_t            buf_req,
  output xcbs_pkg::step_t               step
);
  import xcbs_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  load_count, load_count_next;
  logic [7:0]  send_position, send_position_next;
  logic [15:0] block_counter, block_counter_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] wait_remaining, wait_remaining_next;
  logic [15:0] block_remaining, block_remaining_next;
  logic [15:0] block_inc;
  logic [15:0] block_rem_dec;
  logic [7:0]  seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      load_count      <= '0;
      send_position   <= '0;
      block_counter   <= '0;
      running_crc     <= '0;
      wait_remaining  <= '0;
      block_remaining <= '0;
    end else begin
      phase           <= phase_next;
      load_count      <= load_count_next;
      send_position   <= send_position_next;
      block_counter   <= block_counter_next;
      running_crc     <= running_crc_next;
      wait_remaining  <= wait_remaining_next;
      block_remaining <= block_remaining_next;
    end
  end

  assign block_inc     = block_counter + 16'd1;
  assign block_rem_dec = (block_remaining <= 16'd1) ? 16'd0 : block_remaining - 16'd1;
  assign seq           = block_counter[7:0];

  always_comb begin
    phase_next           = phase;
    load_count_next      = load_count;
    send_position_next   = send_position;
    block_counter_next   = block_counter;
    running_crc_next     = running_crc;
    wait_remaining_next  = wait_remaining;
    block_remaining_next = block_remaining;
    // A transmit slot's data byte is read here and picked up as stage one advances.
    buf_req.re           = accept;
    buf_req.raddr        = BUF_AW'(send_position - HDR_BYTES);
    buf_req.waddr        = BUF_AW'(load_count);
    buf_req.wdata        = value;
    buf_req.we           = 1'b0;
    step.tx_valid        = 1'b0;
    step.use_buf         = 1'b0;
    step.tx_byte         = 8'h00;

    if (accept) begin
      case (opcode_t'(opcode))
        OP_START: begin
          phase_next           = PH_WAITC;
          wait_remaining_next  = cfg.start_wait_ticks;
          block_counter_next   = '0;
          load_count_next      = '0;
          send_position_next   = '0;
          running_crc_next     = '0;
          block_remaining_next = '0;
        end
        OP_PAYLOAD: begin
          if (phase == PH_LOAD && load_count < 8'(BLOCK_BYTES)) begin
            buf_req.we       = 1'b1;
            running_crc_next = crc_byte(running_crc, value);
            load_count_next  = load_count + 8'd1;
            if (load_count == POS_LAST_DATA_LOAD) begin
              phase_next           = PH_SEND;
              send_position_next   = '0;
              block_remaining_next = cfg.block_retry_ticks;
            end
          end
        end
        OP_RX: begin
          if (phase == PH_WAITC && value == CH_C) begin
            if (block_counter == cfg.total_blocks) begin
              phase_next = PH_EOT;
            end else begin
              phase_next       = PH_LOAD;
              load_count_next  = '0;
              running_crc_next = '0;
            end
          end else if (phase == PH_WAITACK && value == CH_ACK) begin
            block_counter_next = block_inc;
            if (block_inc == cfg.total_blocks) begin
              phase_next = PH_EOT;
            end else begin
              phase_next       = PH_LOAD;
              load_count_next  = '0;
              running_crc_next = '0;
            end
          end else if (phase == PH_FINAL && value == CH_ACK) begin
            phase_next = PH_DONE;
          end
        end
        OP_TICK: begin
          if (phase == PH_WAITC) begin
            if (wait_remaining <= 16'd1) begin
              wait_remaining_next = '0;
              phase_next          = PH_TMO_START;
            end else begin
              wait_remaining_next = wait_remaining - 16'd1;
            end
          end else if (phase == PH_SEND) begin
            block_remaining_next = block_rem_dec;
          end else if (phase == PH_WAITACK) begin
            block_remaining_next = block_rem_dec;
            if (wait_remaining <= 16'd1) begin
              wait_remaining_next = '0;
              // The retry budget is only looked at when an ACK wait runs out.
              if (block_rem_dec == 16'd0) begin
                phase_next = PH_TMO_BLOCK;
              end else begin
                phase_next         = PH_SEND;
                send_position_next = '0;
              end
            end else begin
              wait_remaining_next = wait_remaining - 16'd1;
            end
          end else if (phase == PH_FINAL) begin
            if (wait_remaining <= 16'd1) begin
              wait_remaining_next = '0;
              phase_next          = PH_DONE;
            end else begin
              wait_remaining_next = wait_remaining - 16'd1;
            end
          end
        end
        OP_TXSLOT: begin
          if (phase == PH_SEND) begin
            step.tx_valid = 1'b1;
            if (send_position == 8'd0) begin
              step.tx_byte = CH_SOH;
            end else if (send_position == 8'd1) begin
              step.tx_byte = seq;
            end else if (send_position == 8'd2) begin
              step.tx_byte = ~seq;
            end else if (send_position < POS_CRC_HI) begin
              step.use_buf = 1'b1;
            end else if (send_position == POS_CRC_HI) begin
              step.tx_byte = running_crc[15:8];
            end else begin
              step.tx_byte = running_crc[7:0];
            end
            if (send_position > POS_CRC_HI) begin
              phase_next          = PH_WAITACK;
              wait_remaining_next = cfg.ack_wait_ticks;
              send_position_next  = '0;
            end else begin
              send_position_next = send_position + 8'd1;
            end
          end else if (phase == PH_EOT) begin
            step.tx_valid       = 1'b1;
            step.tx_byte        = CH_EOT;
            phase_next          = PH_FINAL;
            wait_remaining_next = cfg.final_wait_ticks;
          end
        end
        default: ;
      endcase
    end

    step.status        = phase_next;
    step.current_block = block_counter_next;
  end

endmodule

/* rtl/xmodem_crc_block_sender.sv */
// Channel   Role    Payload                                   Accepted when
// events    sink    opcode[2:0], value[7:0]                   valid && ready
// results   source  tx_valid, tx_byte[7:0], status[3:0],      valid && ready
//                   current_block[15:0]
// APB       slave   5 registers at byte offsets 0x00..0x10    psel && penable && pwrite
//
// One request is taken per cycle while the pipeline is free to move. Each
// request produces exactly one result: it waits in stage one while its buffer
// read for a data byte completes, then passes through the output register. The
// single-port-read block buffer sets this depth. Reset clears the sequencer,
// the pipeline valid bits and the registers; the buffer itself is never
// cleared, since every block is filled before it is sent. A stall on the
// result side backs up into the pipeline stage and only then holds off
// new requests.
module xmodem_crc_block_sender (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xcbs_pkg::PADDR_W-1:0] paddr,
  input  logic [xcbs_pkg::PDATA_W-1:0] pwdata,
  output logic [xcbs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  xcbs_event_if.sink                   events,
  xcbs_result_if.source                results
);
  import xcbs_pkg::*;
  `include "xmodem_crc_block_sender_defines.svh"

  cfg_t     cfg;
  buf_req_t buf_req;
  step_t    step;
  logic     accept;
  logic [7:0] buf_rdata;

  // Stage one holds a processed request while its buffer read completes.
  logic  s1_valid;
  step_t s1;
  logic  s1_advance;

  // Output register facing the result channel.
  logic        o_valid;
  logic        o_tx_valid;
  logic [7:0]  o_tx_byte;
  logic [3:0]  o_status;
  logic [15:0] o_current_block;
  logic        o_free;

  assign pready = 1'b1;

  xcbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  xcbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opcode  (events.opcode),
    .value   (events.value),
    .cfg     (cfg),
    .buf_req (buf_req),
    .step    (step)
  );

  // Writes happen only while loading. A read is issued on every taken request,
  // but only a data slot while sending uses it, and that never meets a write in
  // the same cycle; a read in the cycle after a write already sees the new byte.
  xcbs_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (buf_req.we),
    .waddr (buf_req.waddr),
    .wdata (buf_req.wdata),
    .re    (buf_req.re),
    .raddr (buf_req.raddr),
    .rdata (buf_rdata)
  );

  assign o_free       = !o_valid || results.ready;
  assign s1_advance   = s1_valid && o_free;
  // The buffer read is only issued on a taken request, so its data stays put
  // for as long as stage one is stalled.
  assign events.ready = !s1_valid || o_free;
  assign accept       = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        o_valid <= 1'b1;
      end else if (results.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
    if (s1_advance) begin
      o_tx_valid      <= s1.tx_valid;
      o_tx_byte       <= s1.use_buf ? buf_rdata : s1.tx_byte;
      o_status        <= s1.status;
      o_current_block <= s1.current_block;
    end
  end

  assign results.valid         = o_valid;
  assign results.tx_valid      = o_tx_valid;
  assign results.tx_byte       = o_tx_byte;
  assign results.status        = o_status;
  assign results.current_block = o_current_block;

  // A taken request always lands in stage one.
  `XCBS_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "request lost after accept")
  // A byte goes out only with the status showing the send, ACK-wait or final-wait phase.
  `XCBS_ASSERT_SAME(a_tx_phase, s1_valid && s1.tx_valid, (s1.status == PH_SEND) || (s1.status == PH_WAITACK) || (s1.status == PH_FINAL), "transmit byte outside a sending phase")
  // A data byte from the buffer is always sent while the block is still being sent.
  `XCBS_ASSERT_SAME(a_buf_in_send, s1_valid && s1.use_buf, s1.tx_valid && (s1.status == PH_SEND), "buffer byte used outside sending")
  // The buffer is never written and read for transmission in the same request.
  `XCBS_ASSERT_SAME(a_no_wr_on_tx, buf_req.we, !step.use_buf, "buffer written during a data slot")

endmodule

/* tb/testbench.sv */
module testbench;
  import xcbs_pkg::*;

  // Opcodes 5 to 7 are spare. The sender must ignore them in every phase.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Register indexes above the last real register decode to nothing.
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  // Packet layout on the wire: SOH, seq, ~seq, 128 data bytes, CRC high, CRC low.
  localparam int DATA_START = 3;
  localparam int CRC_HI_POS = DATA_START + BLOCK_BYTES;
  localparam int CRC_LO_POS = CRC_HI_POS + 1;

  localparam int RAND_REQUESTS = 1900;
  localparam int HOLD_AT       = 650;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_LIMIT  = 10;

  // One result as the sender presents it on the result channel.
  typedef struct packed {
    logic        txv;
    logic [7:0]  txb;
    logic [3:0]  st;
    logic [15:0] blk;
  } tx_result_t;

  // One row of the directed table. A row is either an event request or a
  // register write; for a write, code holds the register index.
  typedef struct packed {
    logic       is_cfg;
    logic [2:0] code;
    logic [15:0] data;
    logic       checked;
    tx_result_t want;
  } dir_row_t;

  localparam tx_result_t UNCHECKED = '0;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // Out of reset nothing is armed, so each of these events leaves the sender idle.
    '{1'b0, OP_TICK,    16'h0000, 1'b1, '{1'b0, 8'h00, PH_IDLE, 16'd0}},
    '{1'b0, OP_TXSLOT,  16'h0000, 1'b1, '{1'b0, 8'h00, PH_IDLE, 16'd0}},
    '{1'b0, OP_PAYLOAD, 16'h00FF, 1'b1, '{1'b0, 8'h00, PH_IDLE, 16'd0}},
    '{1'b0, OP_RX,      16'h0043, 1'b1, '{1'b0, 8'h00, PH_IDLE, 16'd0}},
    '{1'b0, OP_SPARE7,  16'h00FF, 1'b1, '{1'b0, 8'h00, PH_IDLE, 16'd0}},
    // Arm, ignore a wrong byte and a tick, then take 'C' with no blocks
    // configured: the sender goes straight to EOT, sends it and ends on ACK.
    '{1'b0, OP_START,   16'h0000, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_RX,      16'h0000, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_TICK,    16'h0000, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_RX,      16'h0043, 1'b1, '{1'b0, 8'h00, PH_EOT, 16'd0}},
    '{1'b0, OP_PAYLOAD, 16'h0000, 1'b1, '{1'b0, 8'h00, PH_EOT, 16'd0}},
    '{1'b0, OP_TXSLOT,  16'h0000, 1'b1, '{1'b1, 8'h04, PH_FINAL, 16'd0}},
    '{1'b0, OP_RX,      16'h0005, 1'b1, '{1'b0, 8'h00, PH_FINAL, 16'd0}},
    '{1'b0, OP_RX,      16'h0006, 1'b1, '{1'b0, 8'h00, PH_DONE, 16'd0}},
    '{1'b0, OP_TICK,    16'h0000, 1'b1, '{1'b0, 8'h00, PH_DONE, 16'd0}},
    // Shortest start wait and a zero final wait.
    '{1'b1, REG_START_WAIT, 16'h0001, 1'b0, UNCHECKED},
    '{1'b1, REG_FINAL_WAIT, 16'h0000, 1'b0, UNCHECKED},
    '{1'b0, OP_START,   16'h0000, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_TICK,    16'h0000, 1'b1, '{1'b0, 8'h00, PH_TMO_START, 16'd0}},
    '{1'b0, OP_RX,      16'h0043, 1'b1, '{1'b0, 8'h00, PH_TMO_START, 16'd0}},
    '{1'b0, OP_START,   16'h00FF, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_RX,      16'h0043, 1'b1, '{1'b0, 8'h00, PH_EOT, 16'd0}},
    '{1'b0, OP_TXSLOT,  16'h0000, 1'b1, '{1'b1, 8'h04, PH_FINAL, 16'd0}},
    // A tick with the final counter already at zero ends the wait.
    '{1'b0, OP_TICK,    16'h0000, 1'b1, '{1'b0, 8'h00, PH_DONE, 16'd0}},
    // One block, left loading for the random part to carry on.
    '{1'b1, REG_TOTAL_BLOCKS, 16'h0001, 1'b0, UNCHECKED},
    '{1'b0, OP_START,   16'h0000, 1'b1, '{1'b0, 8'h00, PH_WAITC, 16'd0}},
    '{1'b0, OP_RX,      16'h0043, 1'b1, '{1'b0, 8'h00, PH_LOAD, 16'd0}},
    '{1'b0, OP_SPARE5,  16'h0055, 1'b0, UNCHECKED},
    '{1'b0, OP_TICK,    16'h0000, 1'b0, UNCHECKED}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic        pready;

  xcbs_event_if  ev();
  xcbs_result_if res();

  xmodem_crc_block_sender dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .events  (ev),
    .results (res)
  );

  always #1 clk = ~clk;

  // Predictor state: our own copy of the sender and of its registers.
  cfg_t        cfg;
  logic [7:0]  pkt_data [BLOCK_BYTES];
  logic [7:0]  fill_cnt;
  logic [7:0]  tx_pos;
  logic [15:0] blk_idx;
  logic [15:0] crc_acc;
  phase_t      ph;
  logic [15:0] wait_cnt;
  logic [15:0] retry_cnt;

  // Results predicted for accepted requests, oldest first.
  tx_result_t  awaited[$];

  int fail_count;
  int result_count;
  int request_count;
  int in_stall_cycles;
  int n_acked, n_resent, n_done, n_tmo_start, n_tmo_block;

  // Sender pacing: bursts of back-to-back requests with gaps in between.
  int burst_left;

  // Receiver pacing. The main process raises hold_request at HOLD_AT; the
  // receiver then keeps ready low while its own count from HOLD_CYCLES runs.
  bit hold_request;
  int hold_left;
  int pattern_left;
  int stall_pct;

  // CRC-16/XMODEM, one bit at a time, MSB first.
  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  // Counters stop at zero instead of wrapping.
  function automatic logic [15:0] dec_sat(logic [15:0] c);
    return (c <= 16'd1) ? 16'd0 : c - 16'd1;
  endfunction

  task automatic reset_predictor();
    cfg.total_blocks      = '0;
    cfg.start_wait_ticks  = RST_START_WAIT;
    cfg.ack_wait_ticks    = RST_ACK_WAIT;
    cfg.block_retry_ticks = RST_RETRY;
    cfg.final_wait_ticks  = RST_FINAL_WAIT;
    fill_cnt  = '0;
    tx_pos    = '0;
    blk_idx   = '0;
    crc_acc   = '0;
    ph        = PH_IDLE;
    wait_cnt  = '0;
    retry_cnt = '0;
  endtask

  // Either the transfer is over, or the next block starts loading.
  task automatic open_block();
    if (blk_idx == cfg.total_blocks) begin
      ph = PH_EOT;
    end else begin
      ph       = PH_LOAD;
      fill_cnt = '0;
      crc_acc  = '0;
    end
  endtask

  // Advances the predictor by one accepted request and returns its result.
  task automatic sender_step(input logic [2:0] op, input logic [7:0] v,
                             output tx_result_t r);
    logic [7:0] seq;
    logic       ran_out;
    r   = '0;
    seq = blk_idx[7:0];
    case (op)
      OP_START: begin
        ph        = PH_WAITC;
        wait_cnt  = cfg.start_wait_ticks;
        blk_idx   = '0;
        fill_cnt  = '0;
        tx_pos    = '0;
        crc_acc   = '0;
        retry_cnt = '0;
      end
      OP_PAYLOAD: begin
        if (ph == PH_LOAD && fill_cnt < BLOCK_BYTES) begin
          pkt_data[fill_cnt[6:0]] = v;
          crc_acc  = crc16_update(crc_acc, v);
          fill_cnt = fill_cnt + 8'd1;
          if (fill_cnt == BLOCK_BYTES) begin
            ph        = PH_SEND;
            tx_pos    = '0;
            retry_cnt = cfg.block_retry_ticks;
          end
        end
      end
      OP_RX: begin
        if (ph == PH_WAITC && v == CH_C) begin
          open_block();
        end else if (ph == PH_WAITACK && v == CH_ACK) begin
          blk_idx = blk_idx + 16'd1;
          n_acked++;
          open_block();
        end else if (ph == PH_FINAL && v == CH_ACK) begin
          ph = PH_DONE;
          n_done++;
        end
      end
      OP_TICK: begin
        case (ph)
          PH_WAITC: begin
            if (wait_cnt <= 16'd1) begin
              ph = PH_TMO_START;
              n_tmo_start++;
            end
            wait_cnt = dec_sat(wait_cnt);
          end
          PH_SEND: begin
            retry_cnt = dec_sat(retry_cnt);
          end
          PH_WAITACK: begin
            // The block budget is only looked at when the ACK wait expires.
            retry_cnt = dec_sat(retry_cnt);
            ran_out   = (wait_cnt <= 16'd1);
            wait_cnt  = dec_sat(wait_cnt);
            if (ran_out) begin
              if (retry_cnt == '0) begin
                ph = PH_TMO_BLOCK;
                n_tmo_block++;
              end else begin
                ph     = PH_SEND;
                tx_pos = '0;
                n_resent++;
              end
            end
          end
          PH_FINAL: begin
            if (wait_cnt <= 16'd1) begin
              ph = PH_DONE;
              n_done++;
            end
            wait_cnt = dec_sat(wait_cnt);
          end
          default: begin
          end
        endcase
      end
      OP_TXSLOT: begin
        if (ph == PH_SEND) begin
          r.txv = 1'b1;
          if (tx_pos == 0) begin
            r.txb = CH_SOH;
          end else if (tx_pos == 1) begin
            r.txb = seq;
          end else if (tx_pos == 2) begin
            r.txb = ~seq;
          end else if (tx_pos < CRC_HI_POS) begin
            r.txb = pkt_data[7'(tx_pos - 8'(DATA_START))];
          end else if (tx_pos == CRC_HI_POS) begin
            r.txb = crc_acc[15:8];
          end else begin
            r.txb = crc_acc[7:0];
          end
          if (tx_pos >= CRC_LO_POS) begin
            ph       = PH_WAITACK;
            wait_cnt = cfg.ack_wait_ticks;
            tx_pos   = '0;
          end else begin
            tx_pos = tx_pos + 8'd1;
          end
        end else if (ph == PH_EOT) begin
          r.txv    = 1'b1;
          r.txb    = CH_EOT;
          ph       = PH_FINAL;
          wait_cnt = cfg.final_wait_ticks;
        end
      end
      default: begin
      end
    endcase
    r.st  = ph;
    r.blk = blk_idx;
  endtask

  // Offers one event request and waits until the sender takes it. At that
  // edge the predictor steps and the result it owes is queued. A directed
  // row may give the result itself; the predictor still steps for its state.
  task automatic offer_event(input logic [2:0] op, input logic [7:0] v,
                             input logic use_given, input tx_result_t given);
    tx_result_t predicted;
    int         gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // A third of the bursts follow the last one with no gap at all, and
      // the long receiver hold-off gets a sender that never pauses.
      gap = ($urandom_range(0, 2) == 0 || hold_left > 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        ev.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    ev.valid  <= 1'b1;
    ev.opcode <= op;
    ev.value  <= v;
    do @(posedge clk); while (!ev.ready);
    sender_step(op, v, predicted);
    awaited.push_back(use_given ? given : predicted);
    request_count++;
  endtask

  // Register writes go in only with nothing in flight: stop offering,
  // then let every owed result come back.
  task automatic settle_idle();
    @(negedge clk);
    ev.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, setup phase then access phase. Only the low 16 bits carry a value; the upper bits
  // are filled at random and must be dropped by the register file.
  task automatic apb_write(input logic [2:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'($urandom_range(0, 65535)), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TOTAL_BLOCKS: cfg.total_blocks      = v;
      REG_START_WAIT:   cfg.start_wait_ticks  = v;
      REG_ACK_WAIT:     cfg.ack_wait_ticks    = v;
      REG_BLOCK_RETRY:  cfg.block_retry_ticks = v;
      REG_FINAL_WAIT:   cfg.final_wait_ticks  = v;
      default: begin
      end
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Bytes lean toward both extremes so every bit sees both values early.
  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short waits so that timeouts are reachable, plus the extremes.
  function automatic logic [15:0] pick_wait(int hi);
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic pick_transfer_settings();
    int          r;
    logic [15:0] blocks;
    r = $urandom_range(0, 19);
    if (r < 4) begin
      blocks = 16'd0;
    end else if (r < 14) begin
      blocks = 16'd1;
    end else if (r < 18) begin
      blocks = 16'd2;
    end else if (r < 19) begin
      blocks = 16'd3;
    end else begin
      // Never finishes; it runs until a timeout or the next restart.
      blocks = 16'hFFFF;
    end
    apb_write(REG_TOTAL_BLOCKS, blocks);
    apb_write(REG_START_WAIT, pick_wait(6));
    apb_write(REG_ACK_WAIT, pick_wait(6));
    apb_write(REG_BLOCK_RETRY, pick_wait(40));
    apb_write(REG_FINAL_WAIT, pick_wait(6));
    if ($urandom_range(0, 3) == 0) begin
      apb_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                16'($urandom_range(0, 65535)));
    end
  endtask

  // Chooses the next request from the phase the sender is in, so that most
  // traffic is a well-formed exchange with random content and the rest is
  // noise: spare opcodes, stray bytes, ticks and slots out of place.
  task automatic next_event(output logic [2:0] op, output logic [7:0] v);
    int r;
    r  = $urandom_range(0, 99);
    op = 3'($urandom_range(OP_PAYLOAD, OP_SPARE7));
    v  = rnd_byte();
    case (ph)
      PH_WAITC: begin
        if (r < 55) begin
          op = OP_RX;
          v  = CH_C;
        end else if (r < 80) begin
          op = OP_TICK;
        end else if (r < 92) begin
          op = OP_RX;
        end
      end
      PH_LOAD: begin
        if (r < 92) op = OP_PAYLOAD;
      end
      PH_SEND: begin
        if (r < 85) begin
          op = OP_TXSLOT;
        end else if (r < 95) begin
          op = OP_TICK;
        end
      end
      PH_WAITACK: begin
        if (r < 55) begin
          op = OP_RX;
          v  = CH_ACK;
        end else if (r < 85) begin
          op = OP_TICK;
        end else if (r < 95) begin
          op = OP_RX;
        end
      end
      PH_EOT: begin
        if (r < 80) op = OP_TXSLOT;
      end
      PH_FINAL: begin
        if (r < 50) begin
          op = OP_RX;
          v  = CH_ACK;
        end else if (r < 80) begin
          op = OP_TICK;
        end
      end
      default: begin
      end
    endcase
    // A rare restart lands in whatever phase the transfer has reached.
    if ($urandom_range(0, 499) == 0) op = OP_START;
  endtask

  // Receiver: ready changes at the falling edge, with a stall rate that
  // moves between stretches of no stalls and stretches of moderate to heavy ones.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 60;
        default: stall_pct = 85;
      endcase
    end
    pattern_left--;
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker. Every accepted result is matched against the oldest
  // owed one; a result nobody is waiting for is a failure too.
  always @(posedge clk) begin
    tx_result_t got;
    tx_result_t want;
    if (!rst && ev.valid && !ev.ready) in_stall_cycles++;
    if (!rst && res.valid && res.ready) begin
      got = {res.tx_valid, res.tx_byte, res.status, res.current_block};
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Unexpected result: tx_valid=%0b tx_byte=%02h status=%0d block=%0d",
                   got.txv, got.txb, got.st, got.blk);
        end
      end else begin
        want = awaited.pop_front();
        if (got.txv !== want.txv || got.txb !== want.txb ||
            got.st !== want.st || got.blk !== want.blk) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Mismatch on result %0d: expected tx_valid=%0b tx_byte=%02h status=%0d block=%0d",
                     result_count, want.txv, want.txb, want.st, want.blk);
            $display("                       got tx_valid=%0b tx_byte=%02h status=%0d block=%0d",
                     got.txv, got.txb, got.st, got.blk);
          end
        end
      end
      result_count++;
    end
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [2:0] op;
    logic [7:0] v;
    int         rand_count;
    clk          = 1'b0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    ev.valid     = 1'b0;
    ev.opcode    = '0;
    ev.value     = '0;
    res.ready    = 1'b0;
    hold_request = 1'b0;
    hold_left    = 0;
    pattern_left = 0;
    stall_pct    = 0;
    burst_left   = 0;
    rand_count   = 0;
    reset_predictor();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: idle behavior, the empty transfer, the start timeout
    // and the zero-length final wait, then into loading a first block.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        settle_idle();
        apb_write(DIR_TAB[i].code, DIR_TAB[i].data);
      end else begin
        offer_event(DIR_TAB[i].code, DIR_TAB[i].data[7:0], DIR_TAB[i].checked,
                    DIR_TAB[i].want);
      end
    end

    // Random part. Once a transfer has ended, either noise is offered (and
    // not counted, since the sender merely ignores it) or a new transfer is
    // started, often with fresh register settings.
    while (rand_count < RAND_REQUESTS) begin
      if (ph == PH_IDLE || ph == PH_DONE || ph == PH_TMO_START || ph == PH_TMO_BLOCK) begin
        if ($urandom_range(0, 99) < 15) begin
          offer_event(3'($urandom_range(OP_PAYLOAD, OP_SPARE7)), rnd_byte(), 1'b0,
                      UNCHECKED);
        end else begin
          if ($urandom_range(0, 1) == 1) begin
            settle_idle();
            pick_transfer_settings();
          end
          offer_event(OP_START, rnd_byte(), 1'b0, UNCHECKED);
          rand_count++;
        end
      end else begin
        next_event(op, v);
        offer_event(op, v, 1'b0, UNCHECKED);
        rand_count++;
      end
      // Once in the run, the receiver stops taking results for a long
      // stretch while requests keep coming, so the sender has to back up.
      if (rand_count == HOLD_AT) hold_request = 1'b1;
    end

    // Drain, then watch a little longer for results that should not come.
    @(negedge clk);
    ev.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests and %0d results: %0d blocks acknowledged, %0d resends,",
             request_count, result_count, n_acked, n_resent);
    $display("%0d transfers done, %0d start and %0d block timeouts, %0d input stall cycles.",
             n_done, n_tmo_start, n_tmo_block, in_stall_cycles);
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
